/* src/bb3_pkg.sv */
// bb3_pkg: types, widths and constants shared by the 3x3 box blur files.
// No dependencies.
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 10;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 48;
    localparam int SUM_W        = 12;
    localparam int NUM_W        = SUM_W + 1;
    localparam int CNT_W        = 4;
    localparam int RECIP_W      = 20;
    localparam int RECIP_SHIFT  = 20;
    localparam int PROD_W       = NUM_W + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic row_last;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } t_pos_flags;

    // ceil(2^20 / (2*cnt)); exact quotient for numerators below 2^13
    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58255;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage

/* src/bb3_ram.sv */
// bb3_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies; read returns the old data on a same-address write.
`timescale 1ns / 1ps

module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/box_blur_3x3_unit.sv */
// box_blur_3x3_unit: streaming 3x3 box blur over RGB pixels in raster order.
// Depends on bb3_pkg and bb3_ram (two line stores).
//
// Pixels enter in raster order for a frame of image_width x image_height
// (zero reads as 1, values above MAX_WIDTH / MAX_HEIGHT saturate). Each centre
// is emitted as soon as its last in-frame neighbour has arrived, as the
// rounded-half-up mean of its in-frame 3x3 neighbours, so one pixel yields
// zero to four results, in row then column order; tlast marks the last of
// them. The block takes one pixel per clock while each pixel yields at most
// one result and the output is not stalled; the centre sequencer emits one
// result per clock while the output accepts, so a pixel yielding several
// results stalls the input until its last is issued (row ends and pixels of
// the last row two, the frame's last pixel up to four). The two line stores
// are MAX_WIDTH x 24 RAMs with a registered read, read at pixel entry and
// written when the pixel leaves the entry stage for the window; a same-column
// write/read pair (width 1) is forwarded. A pixel passes the entry stage, the
// window, the sum stage and the output register. No clearing pass after reset.
// A configuration write restarts the frame at row 0, column 0.
`timescale 1ns / 1ps

module box_blur_3x3_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,   // in_blue, in_green, in_red
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,   // out_blue, out_green, out_red,
                                                      // out_row, out_column, 2'b0
    output logic                    o_m_axis_tlast,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration and frame position
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic [CW-1:0]           r_col_pos, n_col_pos;
    logic [RW-1:0]           r_row_pos, n_row_pos;
    t_pos_flags              cur_flags;
    logic                    in_fire, cfg_fire;

    // entry stage: line store read in flight
    logic             r_s0_valid;
    logic [PIX_W-1:0] r_s0_pix;
    logic [CW-1:0]    r_s0_col;
    logic [RW-1:0]    r_s0_row;
    t_pos_flags       r_s0_flags;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_old, r_fwd_new;
    logic [PIX_W-1:0] older_q, newer_q, up2, up1;
    logic             s0_adv;

    // window and centre sequencer
    logic [PIX_W-1:0] r_win [9];
    logic [3:0]       r_job_mask, mask_rest;
    logic [CW-1:0]    r_job_col;
    logic [RW-1:0]    r_job_row;
    t_pos_flags       r_job_flags;
    logic [1:0]       sel;
    logic             job_issue, job_last;
    logic [2:0]       rowv, colv;
    logic [8:0]       inc;
    logic [SUM_W-1:0] cen_sum [3];
    logic [CNT_W-1:0] cen_cnt;
    logic [OUT_ROW_W-1:0] cen_row;
    logic [OUT_COL_W-1:0] cen_col;

    // sum stage and output register
    logic             r_p1_valid, p1_ready;
    logic [SUM_W-1:0] r_p1_sum [3];
    logic [CNT_W-1:0] r_p1_cnt;
    logic [OUT_ROW_W-1:0] r_p1_row;
    logic [OUT_COL_W-1:0] r_p1_col;
    logic             r_p1_last;
    logic [RECIP_W-1:0] recip;
    logic [NUM_W-1:0] num  [3];
    logic [PROD_W-1:0] prod [3];
    logic             r_out_valid, out_ready;
    logic [CH_W-1:0]  r_out_chan [3];
    logic [OUT_ROW_W-1:0] r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;
    logic             r_out_last;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign in_fire     = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_W'(1);
            r_cfg_height <= CFG_HEIGHT_W'(1);
        end else if (cfg_fire) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= CFG_WIDTH_W'(i_cfg_data);
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_height);
        end
    end

    always_comb begin
        cur_flags.row_ge1  = (r_row_pos != '0);
        cur_flags.row_ge2  = (32'(r_row_pos) >= 32'd2);
        cur_flags.row_last = ((32'(r_row_pos) + 32'd1) == 32'(h_eff));
        cur_flags.col_ge1  = (r_col_pos != '0);
        cur_flags.col_ge2  = (32'(r_col_pos) >= 32'd2);
        cur_flags.col_last = ((32'(r_col_pos) + 32'd1) == 32'(w_eff));
    end

    always_comb begin
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        if (cfg_fire) begin
            n_col_pos = '0;
            n_row_pos = '0;
        end else if (in_fire) begin
            if ((32'(r_col_pos) + 32'd1) >= 32'(w_eff)) begin
                n_col_pos = '0;
                if ((32'(r_row_pos) + 32'd1) >= 32'(h_eff)) begin
                    n_row_pos = '0;
                end else begin
                    n_row_pos = r_row_pos + 1'b1;
                end
            end else begin
                n_col_pos = r_col_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
        end
    end

    // line stores: read at entry, written when the pixel moves into the window
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (s0_adv),
        .i_waddr (r_s0_col),
        .i_wdata (up1),
        .i_re    (in_fire),
        .i_raddr (r_col_pos),
        .o_rdata (older_q)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (s0_adv),
        .i_waddr (r_s0_col),
        .i_wdata (r_s0_pix),
        .i_re    (in_fire),
        .i_raddr (r_col_pos),
        .o_rdata (newer_q)
    );

    assign up2 = r_fwd ? r_fwd_old : older_q;
    assign up1 = r_fwd ? r_fwd_new : newer_q;

    assign o_s_axis_tready = !r_s0_valid || s0_adv;
    assign s0_adv = r_s0_valid && ((r_job_mask == '0) || (job_issue && job_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s0_valid <= 1'b1;
                r_fwd      <= s0_adv && (r_s0_col == r_col_pos);
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s0_pix   <= i_s_axis_tdata;
            r_s0_col   <= r_col_pos;
            r_s0_row   <= r_row_pos;
            r_s0_flags <= cur_flags;
            r_fwd_old  <= up1;
            r_fwd_new  <= r_s0_pix;
        end
    end

    // window shift and job load
    always_ff @(posedge i_clk) begin
        if (s0_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3+0] <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2]    <= up2;
            r_win[5]    <= up1;
            r_win[8]    <= r_s0_pix;
            r_job_col   <= r_s0_col;
            r_job_row   <= r_s0_row;
            r_job_flags <= r_s0_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_mask <= '0;
        end else if (s0_adv) begin
            r_job_mask <= {r_s0_flags.row_last & r_s0_flags.col_last,
                           r_s0_flags.row_last & r_s0_flags.col_ge1,
                           r_s0_flags.row_ge1  & r_s0_flags.col_last,
                           r_s0_flags.row_ge1  & r_s0_flags.col_ge1};
        end else if (job_issue) begin
            r_job_mask <= mask_rest;
        end
    end

    // centre selection: bit index = ky*2 + kx
    always_comb begin
        if (r_job_mask[0]) begin
            sel = 2'd0;
        end else if (r_job_mask[1]) begin
            sel = 2'd1;
        end else if (r_job_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        mask_rest = r_job_mask & ~(4'b0001 << sel);
        job_last  = (mask_rest == '0);
        job_issue = (r_job_mask != '0) && p1_ready;
    end

    always_comb begin
        rowv = {1'b1, r_job_flags.row_ge1, r_job_flags.row_ge2};
        colv = {1'b1, r_job_flags.col_ge1, r_job_flags.col_ge2};
        for (int wr = 0; wr < 3; wr++) begin
            for (int wc = 0; wc < 3; wc++) begin
                inc[wr*3+wc] = rowv[wr] && (wr >= 32'(sel[1])) &&
                               colv[wc] && (wc >= 32'(sel[0]));
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            cen_sum[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                if (inc[k]) begin
                    cen_sum[ch] = cen_sum[ch] + SUM_W'(r_win[k][ch*CH_W +: CH_W]);
                end
            end
        end
        cen_cnt = CNT_W'($countones(inc));
        cen_row = OUT_ROW_W'(sel[1] ? r_job_row : r_job_row - 1'b1);
        cen_col = OUT_COL_W'(sel[0] ? r_job_col : r_job_col - 1'b1);
    end

    // sum stage
    assign out_ready = !r_out_valid || i_m_axis_tready;
    assign p1_ready  = !r_p1_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (p1_ready) begin
            r_p1_valid <= job_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_issue) begin
            r_p1_sum  <= cen_sum;
            r_p1_cnt  <= cen_cnt;
            r_p1_row  <= cen_row;
            r_p1_col  <= cen_col;
            r_p1_last <= job_last;
        end
    end

    // (2*sum + cnt) div (2*cnt) by reciprocal multiply
    always_comb begin
        recip = bb3_recip(r_p1_cnt);
        for (int ch = 0; ch < 3; ch++) begin
            num[ch]  = {r_p1_sum[ch], 1'b0} + NUM_W'(r_p1_cnt);
            prod[ch] = PROD_W'(num[ch]) * PROD_W'(recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid && out_ready) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_chan[ch] <= prod[ch][RECIP_SHIFT +: CH_W];
            end
            r_out_row  <= r_p1_row;
            r_out_col  <= r_p1_col;
            r_out_last <= r_p1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {2'b00, r_out_col, r_out_row,
                              r_out_chan[2], r_out_chan[1], r_out_chan[0]};

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_p1_cnt >= CNT_W'(1)) && (r_p1_cnt <= CNT_W'(9)))
        else $error("neighbour count out of range");

    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> ((prod[0] >> (RECIP_SHIFT + CH_W)) == '0) &&
                       ((prod[1] >> (RECIP_SHIFT + CH_W)) == '0) &&
                       ((prod[2] >> (RECIP_SHIFT + CH_W)) == '0))
        else $error("mean exceeds channel range");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col_pos) < 32'(w_eff)) && (32'(r_row_pos) < 32'(h_eff)))
        else $error("position outside frame");

    a_corner_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_adv && r_s0_flags.row_last && r_s0_flags.col_last &&
        r_s0_flags.row_ge1 && r_s0_flags.col_ge1 |=> $countones(r_job_mask) == 4)
        else $error("frame corner did not schedule four centres");

endmodule

/* tb/box_blur_3x3_checker.sv */
// box_blur_3x3_checker: watches the config, pixel and result channels of the box blur,
// predicts every blurred pixel in order and compares each result transfer field by field.
// Depends on bb3_pkg.
`timescale 1ns / 1ps

module box_blur_3x3_checker
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int ROW_LSB = PIX_W;
    localparam int COL_LSB = PIX_W + OUT_ROW_W;

    typedef struct packed {
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      red;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] column;
        logic                 last;
    } t_blur_mean;

    logic [PIX_W-1:0]        older_line [MAX_WIDTH];
    logic [PIX_W-1:0]        newer_line [MAX_WIDTH];
    logic [PIX_W-1:0]        window [9];
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    int                      next_row;
    int                      next_col;
    t_blur_mean              pending_means [$];
    int                      mismatch_count = 0;
    int                      means_checked  = 0;
    int                      queued_means   = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = queued_means;
    assign o_checked = means_checked;

    function automatic int frame_width();
        if (width_reg == 0) return 1;
        if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int frame_height();
        if (height_reg == 0) return 1;
        if (int'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // window holds columns c-2..c of rows r-2..r, (r, c) being the newest pixel
    function automatic t_blur_mean mean_around(int y, int x, int r, int c, int h, int w);
        int unsigned sum_b, sum_g, sum_r, cnt;
        int          ny, nx, wr, wc;
        logic [PIX_W-1:0] px;
        t_blur_mean  res;
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        cnt   = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                ny = y + dy;
                nx = x + dx;
                wr = ny - (r - 2);
                wc = nx - (c - 2);
                if (ny >= 0 && ny < h && nx >= 0 && nx < w &&
                    wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
                    px = window[wr * 3 + wc];
                    sum_b += px[0 +: CH_W];
                    sum_g += px[CH_W +: CH_W];
                    sum_r += px[2 * CH_W +: CH_W];
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        res.blue   = CH_W'((2 * sum_b + cnt) / (2 * cnt));
        res.green  = CH_W'((2 * sum_g + cnt) / (2 * cnt));
        res.red    = CH_W'((2 * sum_r + cnt) / (2 * cnt));
        res.row    = OUT_ROW_W'(y);
        res.column = OUT_COL_W'(x);
        res.last   = 1'b0;
        return res;
    endfunction

    task automatic blur_incoming_pixel(input logic [PIX_W-1:0] px);
        int         w, h, r, c, n_rows, n_cols, total, idx;
        logic       row_ok, col_ok;
        t_blur_mean res;
        w = frame_width();
        h = frame_height();
        if (next_col >= w || next_row >= h) begin
            next_row = 0;
            next_col = 0;
        end
        r = next_row;
        c = next_col;
        for (int k = 0; k < 3; k++) begin
            window[k * 3]     = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = older_line[c];
        window[5] = newer_line[c];
        window[8] = px;
        older_line[c] = newer_line[c];
        newer_line[c] = px;

        n_rows = int'(r >= 1) + int'(r + 1 == h);
        n_cols = int'(c >= 1) + int'(c + 1 == w);
        total  = n_rows * n_cols;
        idx    = 0;
        for (int ky = 0; ky < 2; ky++) begin
            for (int kx = 0; kx < 2; kx++) begin
                row_ok = (ky == 0) ? (r >= 1) : (r + 1 == h);
                col_ok = (kx == 0) ? (c >= 1) : (c + 1 == w);
                if (row_ok && col_ok) begin
                    idx++;
                    res      = mean_around(r - 1 + ky, c - 1 + kx, r, c, h, w);
                    res.last = (idx == total);
                    pending_means.push_back(res);
                end
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_mean();
        t_blur_mean want;
        if (pending_means.size() == 0) begin
            $error("result transfer with no expected result: tdata %h", i_m_tdata);
            mismatch_count++;
        end else begin
            want = pending_means.pop_front();
            compare_field("out_blue", want.blue, i_m_tdata[0 +: CH_W]);
            compare_field("out_green", want.green, i_m_tdata[CH_W +: CH_W]);
            compare_field("out_red", want.red, i_m_tdata[2 * CH_W +: CH_W]);
            compare_field("out_row", want.row, i_m_tdata[ROW_LSB +: OUT_ROW_W]);
            compare_field("out_column", want.column, i_m_tdata[COL_LSB +: OUT_COL_W]);
            compare_field("last_of_run", want.last, i_m_tlast);
            means_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = CFG_WIDTH_W'(1);
            height_reg = CFG_HEIGHT_W'(1);
            next_row   = 0;
            next_col   = 0;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (int i = 0; i < 9; i++) window[i] = '0;
            pending_means.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[CFG_HEIGHT_W-1:0];
                    default: ;
                endcase
                next_row = 0;
                next_col = 0;
            end
            if (i_s_tvalid && i_s_tready) blur_incoming_pixel(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_mean();
        end
        queued_means = pending_means.size();
    end

endmodule

/* tb/box_blur_3x3_unit_tb.sv */
// box_blur_3x3_unit_tb: drives frame settings and pixel streams into the box blur with
// random gaps and stalls, and reports the verdict from the checker's error count.
// Depends on bb3_pkg, box_blur_3x3_unit and box_blur_3x3_checker.
`timescale 1ns / 1ps

module box_blur_3x3_unit_tb;
    import bb3_pkg::*;

    localparam int          MAX_W        = 1024;
    localparam int          MAX_H        = 4096;
    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 6;
    localparam int          SETTLE       = 12;
    localparam int          LONG_HOLD    = 80;
    localparam int          TOTAL_ITEMS  = 330;
    localparam int unsigned CYCLE_LIMIT  = 200_000;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;

    int          chk_errors;
    int          chk_pending;
    int          chk_checked;
    int unsigned cycle_count   = 0;
    bit          burst_mode    = 1'b0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          pixels_sent   = 0;
    int          settings_used = 0;
    int unsigned cur_w         = 1;
    int unsigned cur_h         = 1;

    box_blur_3x3_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    box_blur_3x3_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tlast   (o_m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, chk_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] px;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(0, 7))
                0:       px[ch * CH_W +: CH_W] = '0;
                1:       px[ch * CH_W +: CH_W] = '1;
                default: px[ch * CH_W +: CH_W] = CH_W'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixels_sent++;
    endtask

    // source goes quiet, every expected mean must arrive, then pixels that
    // make no result get time to leave the pipeline
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mode: 0 width then height, 1 height then width, 2 width only, 3 height only
    task automatic set_frame(input int unsigned w, h, input int mode);
        t_cfg_reg order [$];
        wait_drained();
        case (mode)
            0:       order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT};
            1:       order = '{CFG_IMAGE_HEIGHT, CFG_IMAGE_WIDTH};
            2:       order = '{CFG_IMAGE_WIDTH};
            default: order = '{CFG_IMAGE_HEIGHT};
        endcase
        foreach (order[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= (order[k] == CFG_IMAGE_WIDTH) ? CFG_DATA_W'(w) : CFG_DATA_W'(h);
            do @(posedge i_clk); while (!o_cfg_ready);
            if (order[k] == CFG_IMAGE_WIDTH) cur_w = w;
            else cur_h = h;
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin : sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    initial begin : stimulus
        int unsigned w, h, eff_w, eff_h, area, n_pix;
        int          mode;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size is 1x1: every pixel is its own mean
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(rand_pixel());

        // zero width and height read as one
        set_frame(0, 0, 0);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);

        // one column, two rows: halves round up
        set_frame(1, 2, 1);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);

        // full 3x3 frame, last pixel releases four centres
        set_frame(3, 3, 0);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFF00FF : 24'h00FF00);

        // oversized registers saturate; partial frames cut short by the next write
        set_frame(2047, 1, 0);
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
        set_frame(1, 8191, 1);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());

        // back-pressure: sink holds off while the source streams two 8x4 frames
        set_frame(8, 4, 0);
        burst_mode = 1'b1;
        hold_requests++;
        for (int i = 0; i < 64; i++) send_pixel(rand_pixel());

        while (pixels_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1) ? 2047 : 1024;
                1:       w = 0;
                2, 3:    w = $urandom_range(9, 24);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 1) ? 8191 : 4096;
                1:       h = 0;
                default: h = $urandom_range(1, 6);
            endcase
            mode = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
            set_frame(w, h, mode);
            burst_mode = ($urandom_range(0, 3) == 0);

            eff_w = clamp_size(cur_w, MAX_W);
            eff_h = clamp_size(cur_h, MAX_H);
            area  = eff_w * eff_h;
            if (area <= 48) begin
                n_pix = area * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0) n_pix += $urandom_range(1, area);
            end else begin
                n_pix = $urandom_range(8, 40);
            end
            if (int'(n_pix) > TOTAL_ITEMS - pixels_sent) begin
                n_pix = unsigned'(TOTAL_ITEMS - pixels_sent);
            end
            for (int unsigned i = 0; i < n_pix; i++) send_pixel(rand_pixel());
        end

        wait_drained();
        @(negedge i_clk);
        $display("Sent %0d pixels under %0d frame settings, %0d blurred pixels checked",
                 pixels_sent, settings_used, chk_checked);
        $display("Sizes ranged from 1x1 to saturated 1024 wide and 4096 high, gaps and stalls 0-4");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
